@@ hdl/pafr_pkg.sv @@
package pafr_pkg;

    // Number of Philox rounds; one pipeline stage per round.
    localparam int unsigned ROUNDS = 10;

    localparam logic [31:0] MUL_A  = 32'hd2511f53;
    localparam logic [31:0] MUL_B  = 32'hcd9e8d57;
    localparam logic [31:0] BUMP_0 = 32'h9e3779b9;
    localparam logic [31:0] BUMP_1 = 32'hbb67ae85;

    localparam int unsigned ROT_DIR   = 11;
    localparam int unsigned ROT_STAGE = 17;
    localparam int unsigned ROT_PURP  = 5;
    localparam int unsigned ROT_ONE   = 23;

    // Configuration port: 64-bit registers at byte address 8*i.
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned CFG_W    = 64;
    localparam logic        REG_SEED_KEY = 1'b0;

    localparam int unsigned IN_W  = 224;
    localparam int unsigned OUT_W = 128;

    typedef struct packed {
        logic [3:0][31:0] x;
        logic [31:0]      k1;
        logic [31:0]      k0;
    } pafr_state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

endpackage

@@ hdl/pafr_round.sv @@
module pafr_round
    import pafr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  pafr_state_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output pafr_state_t out_data
);

    logic        valid_reg;
    pafr_state_t data_reg;
    pafr_state_t data_next;
    logic [63:0] prod_a;
    logic [63:0] prod_b;

    assign prod_a = {32'd0, MUL_A} * {32'd0, in_data.x[0]};
    assign prod_b = {32'd0, MUL_B} * {32'd0, in_data.x[2]};

    always_comb begin
        data_next.x[0] = prod_b[63:32] ^ in_data.x[1] ^ in_data.k0;
        data_next.x[1] = prod_b[31:0];
        data_next.x[2] = prod_a[63:32] ^ in_data.x[3] ^ in_data.k1;
        data_next.x[3] = prod_a[31:0];
        data_next.k0   = in_data.k0 + BUMP_0;
        data_next.k1   = in_data.k1 + BUMP_1;
    end

    // The stage takes a new transfer when it is empty or its content moves on.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ hdl/philox_address_fold_rng_unit.sv @@
// Pipeline: one fold stage, then one stage per round.
// Throughput: one transfer per cycle; each stage holds one item and has its own valid bit,
// so a stall at the output fills empty stages before the input side stops.
// Reset: synchronous, active low on aresetn; clears all valid bits and the seed register.
module philox_address_fold_rng_unit
    import pafr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // APB-style configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]   prdata,
    output logic               pready,
    // s_tdata: step_counter[63:0], pair_index[95:64], direction[127:96],
    //          stage[159:128], lane_id[191:160], purpose_tag[223:192]
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,
    // m_tdata: word0[31:0], word1[63:32], word2[95:64], word3[127:96]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata
);

    logic [63:0] seed_key_reg;
    logic        cfg_write;

    logic [63:0] step_counter;
    logic [31:0] pair_index;
    logic [31:0] direction;
    logic [31:0] stage;
    logic [31:0] lane_id;
    logic [31:0] purpose_tag;

    pafr_state_t fold_next;
    logic        fold_valid_reg;
    pafr_state_t fold_data_reg;
    pafr_state_t stage_data  [ROUNDS+1];
    logic [ROUNDS:0] stage_valid;
    logic [ROUNDS:0] stage_ready;

    // Configuration
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[3] == REG_SEED_KEY) ? seed_key_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_key_reg <= '0;
        end else if (cfg_write && (paddr[3] == REG_SEED_KEY)) begin
            seed_key_reg <= pwdata;
        end
    end

    // Input fold
    assign step_counter = s_tdata[63:0];
    assign pair_index   = s_tdata[95:64];
    assign direction    = s_tdata[127:96];
    assign stage        = s_tdata[159:128];
    assign lane_id      = s_tdata[191:160];
    assign purpose_tag  = s_tdata[223:192];

    always_comb begin
        fold_next.x[0] = step_counter[31:0];
        fold_next.x[1] = step_counter[63:32];
        fold_next.x[2] = pair_index ^ rotl32(direction, ROT_DIR);
        fold_next.x[3] = lane_id ^ rotl32(stage, ROT_STAGE);
        fold_next.k0   = seed_key_reg[31:0] ^ rotl32(purpose_tag, ROT_PURP);
        fold_next.k1   = seed_key_reg[63:32] ^ rotl32(32'd1, ROT_ONE);
    end

    assign s_tready = !fold_valid_reg || stage_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_valid_reg <= 1'b0;
        end else if (s_tready) begin
            fold_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            fold_data_reg <= fold_next;
        end
    end

    assign stage_valid[0] = fold_valid_reg;
    assign stage_data[0]  = fold_data_reg;

    // Round pipeline
    for (genvar i = 0; i < ROUNDS; i++) begin : g_round
        pafr_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    assign stage_ready[ROUNDS] = m_tready;
    assign m_tvalid = stage_valid[ROUNDS];
    assign m_tdata  = {stage_data[ROUNDS].x[3], stage_data[ROUNDS].x[2],
                       stage_data[ROUNDS].x[1], stage_data[ROUNDS].x[0]};

`ifndef ASSERT_OFF
    // The input side only stops when the output holds a result that is not taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output side can move");

    // A seed write is visible on the read port in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_write && (paddr[3] == REG_SEED_KEY)) |=> (seed_key_reg == $past(pwdata)))
        else $error("seed register write lost");

    // The fold stage keeps an item that it holds until the first round stage takes it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid[0] && !stage_ready[0]) |=> stage_valid[0])
        else $error("fold stage dropped an item");
`endif

endmodule

@@ tb/sv/philox_draw_checker.sv @@
`timescale 1ns / 100ps

module philox_draw_checker
    import pafr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]   pwdata,
    input  logic [CFG_W-1:0]   prdata,
    input  logic               pready,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [OUT_W-1:0]   m_tdata,
    output int unsigned        mismatches,
    output int unsigned        draws_pending
);

    localparam logic [PADDR_W-1:0] SEED_ADDR = PADDR_W'(8 * REG_SEED_KEY);

    logic [63:0]      seed_shadow;
    logic [OUT_W-1:0] draws_due[$];
    logic [OUT_W-1:0] oldest_draw;

    function automatic logic [31:0] rot_left(input logic [31:0] v, input int unsigned n);
        logic [63:0] doubled;
        doubled = {v, v} << n;
        return doubled[63:32];
    endfunction

    // Folds the address into counter and key, then runs the Philox rounds.
    function automatic logic [OUT_W-1:0] philox_draw(input logic [IN_W-1:0] addr,
                                                     input logic [63:0] seed);
        logic [31:0] x0, x1, x2, x3, k0, k1, n0, n2;
        logic [63:0] pa, pb;
        int unsigned r;
        x0 = addr[31:0];
        x1 = addr[63:32];
        x2 = addr[95:64] ^ rot_left(addr[127:96], ROT_DIR);
        x3 = addr[191:160] ^ rot_left(addr[159:128], ROT_STAGE);
        k0 = seed[31:0] ^ rot_left(addr[223:192], ROT_PURP);
        k1 = seed[63:32] ^ rot_left(32'd1, ROT_ONE);
        for (r = 0; r < ROUNDS; r++) begin
            pa = {32'd0, MUL_A} * {32'd0, x0};
            pb = {32'd0, MUL_B} * {32'd0, x2};
            n0 = pb[63:32] ^ x1 ^ k0;
            n2 = pa[63:32] ^ x3 ^ k1;
            x0 = n0;
            x1 = pb[31:0];
            x2 = n2;
            x3 = pa[31:0];
            k0 = k0 + BUMP_0;
            k1 = k1 + BUMP_1;
        end
        return {x3, x2, x1, x0};
    endfunction

    task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            seed_shadow = '0;
            mismatches = 0;
            draws_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (draws_due.size() == 0) begin
                    report("result transfer with no draw due, word0", '0,
                           64'(m_tdata[31:0]));
                end else begin
                    oldest_draw = draws_due.pop_front();
                    for (int j = 0; j < 4; j++) begin
                        if (m_tdata[32*j +: 32] !== oldest_draw[32*j +: 32]) begin
                            report($sformatf("word%0d", j), 64'(oldest_draw[32*j +: 32]),
                                   64'(m_tdata[32*j +: 32]));
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                draws_due.push_back(philox_draw(s_tdata, seed_shadow));
            end
            if (psel && penable && pready && paddr == SEED_ADDR) begin
                if (pwrite) begin
                    seed_shadow = pwdata;
                end else if (prdata !== seed_shadow) begin
                    report("seed_key readback", seed_shadow, prdata);
                end
            end
        end
        draws_pending = draws_due.size();
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import pafr_pkg::*;

    localparam int unsigned        LATENCY    = ROUNDS + 1;
    localparam logic [PADDR_W-1:0] SEED_ADDR  = PADDR_W'(8 * REG_SEED_KEY);
    // The first address past the only register; writes there must be ignored.
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(8 * (REG_SEED_KEY + 1));
    localparam int unsigned        PHASE_ITEMS = 75;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [CFG_W-1:0]   pwdata   = '0;
    logic [CFG_W-1:0]   prdata;
    logic               pready;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;

    int unsigned mismatches;
    int unsigned draws_pending;
    bit          hold_request = 1'b0;
    logic [63:0] seed_plan[6];

    always #5 aclk = ~aclk;

    philox_address_fold_rng_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    philox_draw_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (mismatches),
        .draws_pending (draws_pending)
    );

    // Ends with psel low and an idle wait after the access so that back-to-back calls never
    // drive psel twice in the same time step.
    task automatic cfg_access(input logic is_write, input logic [PADDR_W-1:0] addr,
                              input logic [CFG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Leaves tvalid high after the transfer so back-to-back items need no toggle.
    task automatic push_item(input logic [IN_W-1:0] item);
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_gap(input int unsigned cycles);
        if (cycles != 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (draws_pending != 0) @(posedge aclk);
    endtask

    function automatic logic [IN_W-1:0] make_item(input logic [63:0] step,
                                                  input logic [31:0] pair, dir, stg,
                                                  input logic [31:0] lane, purp);
        return {purp, lane, stg, dir, pair, step};
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_item();
        logic [63:0] step;
        case ($urandom_range(0, 5))
            0: step = {32'd0, rand_word()};
            1: step = {rand_word(), 32'hffff_ffff};
            2: step = '1;
            default: step = {$urandom, $urandom};
        endcase
        return make_item(step, rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
    endfunction

    task automatic burst_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && sent < count; i++) begin
                push_item(rand_item());
                sent++;
            end
            if ($urandom_range(0, 2) == 0) begin
                idle_gap(0);
            end else begin
                idle_gap($urandom_range(1, 12));
            end
        end
    endtask

    // Result side: segments of full readiness, random stalls, short holds and a long hold on request.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        m_tready <= 1'b1;
                        repeat ($urandom_range(1, 30)) @(posedge aclk);
                    end
                    1: begin
                        repeat ($urandom_range(1, 30)) begin
                            m_tready <= 1'($urandom_range(0, 1));
                            @(posedge aclk);
                        end
                    end
                    2: begin
                        repeat ($urandom_range(1, 30)) begin
                            m_tready <= ($urandom_range(0, 3) != 0);
                            @(posedge aclk);
                        end
                    end
                    default: begin
                        m_tready <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge aclk);
                    end
                endcase
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        cfg_access(1'b0, SEED_ADDR, '0);

        // Field extremes and the bits that wrap around in each rotation.
        push_item(make_item('0, '0, '0, '0, '0, '0));
        push_item(make_item('1, '1, '1, '1, '1, '1));
        push_item(make_item(64'h0000_0000_ffff_ffff, '0, '0, '0, '0, '0));
        idle_gap(1);
        push_item(make_item(64'h0000_0001_0000_0000, '0, '0, '0, '0, '0));
        push_item(make_item(64'h8000_0000_0000_0000, '0, '0, '0, '0, '0));
        push_item(make_item('0, 32'hffff_ffff, '0, '0, '0, '0));
        push_item(make_item('0, '0, 32'h0010_0000, '0, '0, '0));
        idle_gap(2);
        push_item(make_item('0, '0, 32'h0020_0000, '0, '0, '0));
        push_item(make_item('0, '0, '0, 32'h0000_4000, '0, '0));
        push_item(make_item('0, '0, '0, 32'h0000_8000, '0, '0));
        push_item(make_item('0, '0, '0, '0, 32'h8000_0000, '0));
        idle_gap(1);
        push_item(make_item('0, '0, '0, '0, '0, 32'h0400_0000));
        push_item(make_item('0, '0, '0, '0, '0, 32'h0800_0000));
        push_item(make_item('0, '0, '0, '0, '0, 32'hffff_ffff));
        push_item(make_item('0, 32'hffff_ffff, 32'hffff_ffff, '0, '0, '0));
        push_item(make_item('0, '0, '0, 32'hffff_ffff, 32'hffff_ffff, '0));
        drain();

        seed_plan[0] = '1;
        seed_plan[1] = 64'h0000_0000_0000_0001;
        seed_plan[2] = 64'h8000_0000_0000_0000;
        seed_plan[3] = {$urandom, $urandom};
        seed_plan[4] = {$urandom, $urandom};
        seed_plan[5] = '0;

        for (int p = 0; p < 6; p++) begin
            cfg_access(1'b1, SEED_ADDR, seed_plan[p]);
            if (p == 2) begin
                cfg_access(1'b1, SPARE_ADDR, {$urandom, $urandom});
            end
            cfg_access(1'b0, SEED_ADDR, '0);
            if (p == 0) begin
                // Output held off while the input keeps offering, so the pipe fills.
                hold_request = 1'b1;
                for (int i = 0; i < 80; i++) begin
                    push_item(rand_item());
                end
            end
            burst_traffic(PHASE_ITEMS);
            drain();
        end

        repeat (LATENCY) @(posedge aclk);
        if (mismatches == 0 && draws_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
